// File: rtl/core/path_waypoint_densifier_macros.svh
// Assertion helpers for the waypoint densifier.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PATH_WAYPOINT_DENSIFIER_MACROS_SVH
`define PATH_WAYPOINT_DENSIFIER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PWD_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("densifier assertion failed");

// Next-cycle implication, disabled in reset
`define PWD_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("densifier assertion failed");

`endif

// File: rtl/core/pwd_pkg.sv
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared widths, types and register codes of the path waypoint densifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pwd_pkg;

    localparam int JOINTS = 7;
    localparam int DATA_W = 16;
    localparam int STEP_W = 15;
    localparam int NACT_W = 3;
    localparam int JIDX_W = 3;
    // squared length: sum of up to seven 32-bit squares
    localparam int S_W    = 35;
    localparam int ROOT_W = 18;
    // k*step for k up to 63
    localparam int KS_W   = 21;
    localparam int PROD_W = 2 * KS_W;
    // divider: (2*|diff|*ks + d) / (2*d), quotient never above |diff|
    localparam int NUM_W  = 39;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QUO_W  = 17;
    localparam int CNT_W  = 5;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [DATA_W-1:0]        mag_t;

    // handshake-free status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_STEP_LENGTH   = 1'b0;
    localparam cfg_idx_t CFG_ACTIVE_JOINTS = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 15'd410;
    localparam logic [NACT_W-1:0] NACT_RESET = 3'd7;

endpackage

`default_nettype wire

// File: rtl/core/pwd_isqrt.sv
// ----------------------------------------------------------------------------
// pwd_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_isqrt
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pwd_pkg::S_W-1:0]    radicand,
    output pwd_pkg::unit_stat_t             stat,
    output logic [pwd_pkg::ROOT_W-1:0]      root
);

    localparam int RW = pwd_pkg::S_W + 1;

    logic [RW-1:0]               rem_reg;
    logic [RW-1:0]               res_reg;
    logic [RW-1:0]               bit_reg;
    logic [pwd_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [RW-1:0]               trial;

    assign trial = res_reg + bit_reg;

    // Iterate one root bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= RW'(radicand);
                res_reg  <= '0;
                bit_reg  <= RW'(1) << (pwd_pkg::S_W - 1);
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pwd_pkg::CNT_W'(pwd_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = res_reg[pwd_pkg::ROOT_W-1:0];
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// File: rtl/core/pwd_div.sv
// ----------------------------------------------------------------------------
// pwd_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pwd_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pwd_pkg::NUM_W-1:0]  num,
    input  wire logic [pwd_pkg::DEN_W-1:0]  den,
    output pwd_pkg::unit_stat_t             stat,
    output logic [pwd_pkg::QUO_W-1:0]       quo
);

    localparam int DW = pwd_pkg::DEN_W;
    localparam int QW = pwd_pkg::QUO_W;

    logic [DW:0]                 rem_reg;
    logic [QW-1:0]               low_reg;
    logic [QW-1:0]               quo_reg;
    logic [DW-1:0]               den_reg;
    logic [pwd_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DW:0]                 trial;

    assign trial = {rem_reg[DW-1:0], low_reg[QW-1]};

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= num[QW+DW:QW];
                low_reg  <= num[QW-1:0];
                den_reg  <= den;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                low_reg <= low_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pwd_pkg::CNT_W'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// File: rtl/core/path_waypoint_densifier.sv
// A segment first squares and sums the N active joint differences, checks the
// truncation bound and takes the square root; each stepped point then takes a
// multiply, a divider launch and a divide per joint, then an output beat.
// One waypoint is taken per run; output stalls hold up each emitted point.
// Reset clears the held waypoint and the path flag and loads both registers
// with their defaults.
// ----------------------------------------------------------------------------
// path_waypoint_densifier
// Splits each path segment into points at most step_length apart (if not
// truncated), with one shared multiplier, a serial square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "path_waypoint_densifier_macros.svh"

module path_waypoint_densifier
#(
    parameter int MAX_RUN = 63
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire pwd_pkg::cfg_idx_t              cfg_index,
    input  wire logic [pwd_pkg::STEP_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [15:0]             joint_0,
    input  wire logic signed [15:0]             joint_1,
    input  wire logic signed [15:0]             joint_2,
    input  wire logic signed [15:0]             joint_3,
    input  wire logic signed [15:0]             joint_4,
    input  wire logic signed [15:0]             joint_5,
    input  wire logic signed [15:0]             joint_6,
    input  wire logic                           final_waypoint,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [15:0]                  point_0,
    output logic signed [15:0]                  point_1,
    output logic signed [15:0]                  point_2,
    output logic signed [15:0]                  point_3,
    output logic signed [15:0]                  point_4,
    output logic signed [15:0]                  point_5,
    output logic signed [15:0]                  point_6,
    output logic                                run_end,
    output logic                                truncated
);

    localparam int J   = pwd_pkg::JOINTS;
    localparam int KW  = $clog2(MAX_RUN + 1);
    localparam int DW  = pwd_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_TR_MUL1, ST_TR_MUL2, ST_TR_CMP,
        ST_SQRT_WAIT, ST_TEST_MUL, ST_TEST_CMP, ST_EMIT, ST_PT_MUL,
        ST_PT_DIV_GO, ST_PT_DIV_WAIT, ST_FIN_EMIT, ST_DONE
    } state_t;

    state_t                          state_reg;
    pwd_pkg::coord_t                 prev_reg   [J];
    pwd_pkg::coord_t                 w_reg      [J];
    pwd_pkg::coord_t                 pend_reg   [J];
    pwd_pkg::coord_t                 out_pt_reg [J];
    pwd_pkg::mag_t                   abs_reg    [J];
    logic [J-1:0]                    neg_reg;
    logic                            have_prev_reg;
    logic                            fin_reg;
    logic [pwd_pkg::NACT_W-1:0]      nact_reg;
    logic [pwd_pkg::JIDX_W-1:0]      j_reg;
    logic [pwd_pkg::S_W-1:0]         s_reg;
    logic [pwd_pkg::PROD_W-1:0]      mul_reg;
    logic [pwd_pkg::ROOT_W-1:0]      d_reg;
    logic [pwd_pkg::KS_W-1:0]        ks_reg;
    logic [KW-1:0]                   k_reg;
    logic                            more_reg;
    logic                            trunc_reg;
    logic                            out_valid_reg;
    logic                            run_end_reg;
    logic                            trunc_out_reg;
    logic [pwd_pkg::STEP_W-1:0]      step_reg;
    logic [pwd_pkg::NACT_W-1:0]      active_reg;

    pwd_pkg::coord_t                 w_in [J];
    logic [pwd_pkg::NACT_W-1:0]      nact_clamp;
    logic [pwd_pkg::KS_W-1:0]        mul_a;
    logic [pwd_pkg::KS_W-1:0]        mul_b;
    logic [pwd_pkg::PROD_W-1:0]      mul_next;
    logic                            out_free;
    logic                            emit_load;
    logic                            in_fire;
    logic                            last_joint;
    logic                            sqrt_start;
    logic                            div_start;
    pwd_pkg::unit_stat_t             sqrt_stat;
    pwd_pkg::unit_stat_t             div_stat;
    logic [pwd_pkg::ROOT_W-1:0]      sqrt_root;
    logic [pwd_pkg::QUO_W-1:0]       div_quo;
    logic [pwd_pkg::NUM_W-1:0]       div_num;
    logic [pwd_pkg::DEN_W-1:0]       div_den;
    logic signed [DW+1:0]            step_off;
    logic signed [DW+1:0]            step_sum;

    assign w_in[0] = joint_0;
    assign w_in[1] = joint_1;
    assign w_in[2] = joint_2;
    assign w_in[3] = joint_3;
    assign w_in[4] = joint_4;
    assign w_in[5] = joint_5;
    assign w_in[6] = joint_6;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_load = out_free
                       && ((state_reg == ST_EMIT) || (state_reg == ST_FIN_EMIT));
    assign last_joint = (pwd_pkg::NACT_W'(j_reg) == nact_reg - 1'b1);

    // Clamp the joint count to 1..JOINTS
    always_comb
    begin
        if (active_reg == '0)
            nact_clamp = pwd_pkg::NACT_W'(1);
        else if (active_reg > pwd_pkg::NACT_W'(J))
            nact_clamp = pwd_pkg::NACT_W'(J);
        else
            nact_clamp = active_reg;
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = pwd_pkg::KS_W'(abs_reg[j_reg]);
                mul_b = pwd_pkg::KS_W'(abs_reg[j_reg]);
            end
            ST_TR_MUL1:
            begin
                mul_a = pwd_pkg::KS_W'(MAX_RUN);
                mul_b = pwd_pkg::KS_W'(step_reg);
            end
            ST_TR_MUL2:
            begin
                mul_a = mul_reg[pwd_pkg::KS_W-1:0];
                mul_b = mul_reg[pwd_pkg::KS_W-1:0];
            end
            ST_TEST_MUL:
            begin
                mul_a = ks_reg;
                mul_b = ks_reg;
            end
            ST_PT_MUL:
            begin
                mul_a = pwd_pkg::KS_W'(abs_reg[j_reg]);
                mul_b = ks_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_next = pwd_pkg::PROD_W'(mul_a) * pwd_pkg::PROD_W'(mul_b);

    // Rounded offset: (2*|diff|*ks + d) / (2*d)
    assign div_num = (pwd_pkg::NUM_W'(mul_reg) << 1) + pwd_pkg::NUM_W'(d_reg);
    assign div_den = {d_reg, 1'b0};
    assign sqrt_start = (state_reg == ST_TR_CMP);
    assign div_start  = (state_reg == ST_PT_DIV_GO);

    assign step_off = neg_reg[j_reg] ? -$signed({1'b0, div_quo})
                                     : $signed({1'b0, div_quo});
    assign step_sum = (DW+2)'(prev_reg[j_reg]) + step_off;

    pwd_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (s_reg),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    pwd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Sequencer, state and output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            fin_reg       <= 1'b0;
            nact_reg      <= pwd_pkg::NACT_RESET;
            j_reg         <= '0;
            s_reg         <= '0;
            mul_reg       <= '0;
            d_reg         <= '0;
            ks_reg        <= '0;
            k_reg         <= '0;
            more_reg      <= 1'b0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            run_end_reg   <= 1'b0;
            trunc_out_reg <= 1'b0;
            step_reg      <= pwd_pkg::STEP_RESET;
            active_reg    <= pwd_pkg::NACT_RESET;
            neg_reg       <= '0;
            for (int i = 0; i < J; i++)
            begin
                prev_reg[i]   <= '0;
                w_reg[i]      <= '0;
                pend_reg[i]   <= '0;
                out_pt_reg[i] <= '0;
                abs_reg[i]    <= '0;
            end
        end
        else
        begin
            // Configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pwd_pkg::CFG_STEP_LENGTH:   step_reg   <= cfg_data;
                    pwd_pkg::CFG_ACTIVE_JOINTS:
                        active_reg <= cfg_data[pwd_pkg::NACT_W-1:0];
                    default:                    step_reg   <= step_reg;
                endcase
            end

            // Drop the output beat once taken, unless a new one loads
            if (out_valid_reg && out_ready && !emit_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        fin_reg   <= final_waypoint;
                        nact_reg  <= nact_clamp;
                        trunc_reg <= 1'b0;
                        s_reg     <= '0;
                        j_reg     <= '0;
                        for (int i = 0; i < J; i++)
                        begin
                            logic signed [DW:0] dv;
                            dv = (DW+1)'(w_in[i]) - (DW+1)'(prev_reg[i]);
                            w_reg[i]   <= w_in[i];
                            neg_reg[i] <= dv[DW];
                            abs_reg[i] <= dv[DW] ? DW'(-dv) : DW'(dv);
                        end
                        if (have_prev_reg)
                            state_reg <= ST_SQ_MUL;
                        else if (final_waypoint)
                            state_reg <= ST_FIN_EMIT;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_SQ_MUL:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    s_reg <= s_reg + pwd_pkg::S_W'(mul_reg);
                    if (last_joint)
                        state_reg <= ST_TR_MUL1;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_TR_MUL1:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= ST_TR_MUL2;
                end
                ST_TR_MUL2:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= ST_TR_CMP;
                end
                ST_TR_CMP:
                begin
                    trunc_reg <= (mul_reg < pwd_pkg::PROD_W'(s_reg));
                    ks_reg    <= pwd_pkg::KS_W'(step_reg);
                    k_reg     <= KW'(1);
                    for (int i = 0; i < J; i++)
                        pend_reg[i] <= prev_reg[i];
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT:
                begin
                    if (sqrt_stat.done)
                    begin
                        d_reg     <= sqrt_root;
                        state_reg <= ST_TEST_MUL;
                    end
                end
                ST_TEST_MUL:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= ST_TEST_CMP;
                end
                ST_TEST_CMP:
                begin
                    more_reg  <= (k_reg < KW'(MAX_RUN))
                                 && (mul_reg < pwd_pkg::PROD_W'(s_reg));
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        run_end_reg   <= !more_reg && !fin_reg;
                        trunc_out_reg <= trunc_reg;
                        for (int i = 0; i < J; i++)
                            out_pt_reg[i] <= (pwd_pkg::NACT_W'(i) < nact_reg)
                                             ? pend_reg[i] : '0;
                        j_reg <= '0;
                        if (more_reg)
                            state_reg <= ST_PT_MUL;
                        else if (fin_reg)
                            state_reg <= ST_FIN_EMIT;
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_PT_MUL:
                begin
                    mul_reg   <= mul_next;
                    state_reg <= ST_PT_DIV_GO;
                end
                ST_PT_DIV_GO:
                begin
                    state_reg <= ST_PT_DIV_WAIT;
                end
                ST_PT_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        pend_reg[j_reg] <= step_sum[DW-1:0];
                        if (last_joint)
                        begin
                            ks_reg    <= ks_reg + pwd_pkg::KS_W'(step_reg);
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_TEST_MUL;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_PT_MUL;
                        end
                    end
                end
                ST_FIN_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        run_end_reg   <= 1'b1;
                        trunc_out_reg <= trunc_reg;
                        for (int i = 0; i < J; i++)
                            out_pt_reg[i] <= (pwd_pkg::NACT_W'(i) < nact_reg)
                                             ? w_reg[i] : '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    for (int i = 0; i < J; i++)
                        prev_reg[i] <= w_reg[i];
                    have_prev_reg <= !fin_reg;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign run_end   = run_end_reg;
    assign truncated = trunc_out_reg;
    assign point_0   = out_pt_reg[0];
    assign point_1   = out_pt_reg[1];
    assign point_2   = out_pt_reg[2];
    assign point_3   = out_pt_reg[3];
    assign point_4   = out_pt_reg[4];
    assign point_5   = out_pt_reg[5];
    assign point_6   = out_pt_reg[6];

    // Divider is free whenever a new offset is launched
    `PWD_ASSERT_IMP(a_div_free, div_start, !div_stat.busy)
    // A stepped point never divides by a zero length
    `PWD_ASSERT_IMP(a_len_nonzero, div_start, d_reg != '0)
    // An accepted waypoint blocks the input until its run closes
    `PWD_ASSERT_NXT(a_in_blocked, in_fire, !in_ready)
    // The square root only runs while the sequencer waits on it
    `PWD_ASSERT_IMP(a_sqrt_owned, sqrt_stat.busy,
                    state_reg == ST_SQRT_WAIT)

endmodule

`default_nettype wire
